// ===== hdl/cps_pkg.sv =====
`default_nettype none

package cps_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned PROD_W  = 2 * DIFF_W;
  localparam int unsigned ACC_W   = PROD_W + 2;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned DIST_W  = 64;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic [FRAC_W-1:0]         frac_t;
  typedef logic [DIST_W-1:0]         dist_t;

  typedef struct packed {
    coord_t     target_x;
    coord_t     target_y;
    coord_t     target_z;
    coord_t     seg_start_x;
    coord_t     seg_start_y;
    coord_t     seg_start_z;
    coord_t     seg_end_x;
    coord_t     seg_end_y;
    coord_t     seg_end_z;
    logic       last_segment;
  } req_t;

  typedef struct packed {
    coord_t     near_x;
    coord_t     near_y;
    coord_t     near_z;
    logic       found;
  } rsp_t;

  // Micro-operation sequence of the shared multiplier, three axes per group.
  localparam logic [3:0] OP_DEN  = 4'd0;
  localparam logic [3:0] OP_NUM  = 4'd3;
  localparam logic [3:0] OP_PT   = 4'd6;
  localparam logic [3:0] OP_DIST = 4'd9;
  localparam logic [3:0] OP_LAST = 4'd11;

  typedef enum logic [1:0] {
    GRP_DEN,
    GRP_NUM,
    GRP_PT,
    GRP_DIST
  } grp_e;

endpackage

`default_nettype wire

// ===== hdl/cps_req_if.sv =====
`default_nettype none

interface cps_req_if;
  logic          valid;
  logic          ready;
  cps_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/cps_rsp_if.sv =====
`default_nettype none

interface cps_rsp_if;
  logic          valid;
  logic          ready;
  cps_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/cps_mul.sv =====
`default_nettype none

module cps_mul (
  input  wire logic            clk_i,
  input  wire cps_pkg::diff_t  op_a_i,
  input  wire cps_pkg::diff_t  op_b_i,
  output cps_pkg::prod_t       prod_o
);

  cps_pkg::prod_t prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= cps_pkg::prod_t'(op_a_i) * cps_pkg::prod_t'(op_b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== hdl/cps_div.sv =====
`default_nettype none

module cps_div (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire cps_pkg::acc_t  num_i,
  input  wire cps_pkg::acc_t  den_i,
  output logic                busy_o,
  output cps_pkg::frac_t      quo_o
);

  localparam logic [4:0] STEPS = 5'(cps_pkg::FRAC_W);

  logic                          busy_q, busy_d;
  logic [4:0]                    cnt_q, cnt_d;
  logic [cps_pkg::ACC_W-1:0]     rem_q, rem_d, den_q, den_d, rem2;
  cps_pkg::frac_t                quo_q, quo_d;
  logic                          ge;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem2   = {rem_q[cps_pkg::ACC_W-2:0], 1'b0};
    ge     = (rem2 >= den_q);
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEPS;
      rem_d  = num_i;
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? (rem2 - den_q) : rem2;
      quo_d = {quo_q[cps_pkg::FRAC_W-2:0], ge};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== hdl/closest_point_on_segments.sv =====
// Closest point on a set of 3D segments to a target point, Q16.16 coordinates.
// Requests arrive on req_i, one segment per request together with the target
// and a last_segment flag. The block keeps the nearest candidate of the query
// and, on the request marked last, sends one response on rsp_o with the point
// and a found flag, then clears its running best.
// A zero-length segment stops after the denominator and numerator passes; a
// clamped projection adds the distance pass, and one inside the segment also
// runs the divider and the point pass. The work is set by the one shared 33 by
// 33 multiplier, used up to twelve times per segment, and by the 16-step
// serial divider that forms the projection fraction.
// req_i.ready is high only while the sequencer is idle.
// The response sits in an output register; when the receiver stalls, the next
// query still runs and only its final step waits for the register to empty.
// Reset (rst_ni low) empties the output register and clears the running best.
`default_nettype none

module closest_point_on_segments (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cps_req_if.sink    req_i,
  cps_rsp_if.source  rsp_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_ACC    = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_UPDATE = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [3:0]       op_q, op_d;

  cps_pkg::coord_t  tp_q [3];
  cps_pkg::coord_t  a_q [3];
  cps_pkg::coord_t  b_q [3];
  cps_pkg::coord_t  p_q [3];
  cps_pkg::coord_t  p_d [3];
  logic             last_q;

  cps_pkg::acc_t    den_q, den_d, num_q, num_d, dist_q, dist_d;
  cps_pkg::frac_t   t_q, t_d;

  cps_pkg::dist_t   best_dist_q, best_dist_d, dsq;
  cps_pkg::coord_t  best_q [3];
  cps_pkg::coord_t  best_d [3];
  logic             have_q, have_d;

  cps_pkg::rsp_t    rsp_q, rsp_d;
  logic             out_valid_q, out_valid_d;

  cps_pkg::diff_t   d_w [3];
  cps_pkg::diff_t   e_w [3];
  cps_pkg::diff_t   c_w [3];
  cps_pkg::diff_t   op_a, op_b;
  cps_pkg::prod_t   prod;
  cps_pkg::acc_t    acc_sel, acc_sum;
  cps_pkg::grp_e    grp;
  logic [3:0]       axis_full;
  logic [1:0]       axis;
  logic [cps_pkg::DIFF_W-1:0] pt_sum;

  logic             req_fire;
  logic             div_start, div_busy;
  cps_pkg::frac_t   div_quo;

  assign req_i.ready   = (state_q == S_IDLE);
  assign req_fire      = req_i.valid && req_i.ready;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = rsp_q;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    assign d_w[i] = cps_pkg::diff_t'(b_q[i]) - cps_pkg::diff_t'(a_q[i]);
    assign e_w[i] = cps_pkg::diff_t'(tp_q[i]) - cps_pkg::diff_t'(a_q[i]);
    assign c_w[i] = cps_pkg::diff_t'(tp_q[i]) - cps_pkg::diff_t'(p_q[i]);
  end

  always_comb begin
    grp       = cps_pkg::GRP_DEN;
    axis_full = op_q - cps_pkg::OP_DEN;
    unique case (op_q) inside
      [cps_pkg::OP_DEN : cps_pkg::OP_NUM - 4'd1]: begin
        grp       = cps_pkg::GRP_DEN;
        axis_full = op_q - cps_pkg::OP_DEN;
      end
      [cps_pkg::OP_NUM : cps_pkg::OP_PT - 4'd1]: begin
        grp       = cps_pkg::GRP_NUM;
        axis_full = op_q - cps_pkg::OP_NUM;
      end
      [cps_pkg::OP_PT : cps_pkg::OP_DIST - 4'd1]: begin
        grp       = cps_pkg::GRP_PT;
        axis_full = op_q - cps_pkg::OP_PT;
      end
      default: begin
        grp       = cps_pkg::GRP_DIST;
        axis_full = op_q - cps_pkg::OP_DIST;
      end
    endcase
    axis = axis_full[1:0];
  end

  always_comb begin
    unique case (grp)
      cps_pkg::GRP_DEN: begin
        op_a = d_w[axis];
        op_b = d_w[axis];
      end
      cps_pkg::GRP_NUM: begin
        op_a = e_w[axis];
        op_b = d_w[axis];
      end
      cps_pkg::GRP_PT: begin
        op_a = d_w[axis];
        op_b = cps_pkg::diff_t'({1'b0, t_q});
      end
      default: begin
        op_a = c_w[axis];
        op_b = c_w[axis];
      end
    endcase
  end

  cps_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  cps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  always_comb begin
    unique case (grp)
      cps_pkg::GRP_DEN: acc_sel = den_q;
      cps_pkg::GRP_NUM: acc_sel = num_q;
      default:          acc_sel = dist_q;
    endcase
    acc_sum = acc_sel + cps_pkg::acc_t'(prod);
    pt_sum  = cps_pkg::DIFF_W'(a_q[axis]) + prod[cps_pkg::FRAC_W +: cps_pkg::DIFF_W];
    dsq     = (dist_q[cps_pkg::ACC_W-1:cps_pkg::DIST_W] != '0) ? '1
                                                                : dist_q[cps_pkg::DIST_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    den_d       = den_q;
    num_d       = num_q;
    dist_d      = dist_q;
    t_d         = t_q;
    p_d         = p_q;
    best_dist_d = best_dist_q;
    best_d      = best_q;
    have_d      = have_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    div_start   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          den_d   = '0;
          num_d   = '0;
          dist_d  = '0;
          op_d    = cps_pkg::OP_DEN;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        unique case (grp)
          cps_pkg::GRP_DEN:  den_d = acc_sum;
          cps_pkg::GRP_NUM:  num_d = acc_sum;
          cps_pkg::GRP_PT:   p_d[axis] = pt_sum[cps_pkg::COORD_W-1:0];
          default:           dist_d = acc_sum;
        endcase
        op_d    = op_q + 4'd1;
        state_d = S_MUL;
        if (op_q == cps_pkg::OP_PT - 4'd1) begin
          state_d = S_DECIDE;
        end else if (op_q == cps_pkg::OP_LAST) begin
          state_d = S_UPDATE;
        end
      end
      S_DECIDE: begin
        op_d = cps_pkg::OP_DIST;
        if (den_q == '0) begin
          state_d = S_FINISH;
        end else if (num_q[cps_pkg::ACC_W-1]) begin
          p_d     = a_q;
          state_d = S_MUL;
        end else if (!(num_q < den_q)) begin
          p_d     = b_q;
          state_d = S_MUL;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          t_d     = div_quo;
          op_d    = cps_pkg::OP_PT;
          state_d = S_MUL;
        end
      end
      S_UPDATE: begin
        if (!have_q || (dsq < best_dist_q)) begin
          best_dist_d = dsq;
          best_d      = p_q;
          have_d      = 1'b1;
        end
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (!out_valid_q || rsp_o.ready) begin
          rsp_d.near_x = best_q[0];
          rsp_d.near_y = best_q[1];
          rsp_d.near_z = best_q[2];
          rsp_d.found  = have_q;
          out_valid_d  = 1'b1;
          best_dist_d  = '1;
          best_d       = '{default: '0};
          have_d       = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= cps_pkg::OP_DEN;
      out_valid_q <= 1'b0;
      have_q      <= 1'b0;
      best_dist_q <= '1;
      best_q      <= '{default: '0};
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
      have_q      <= have_d;
      best_dist_q <= best_dist_d;
      best_q      <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      tp_q[0] <= req_i.payload.target_x;
      tp_q[1] <= req_i.payload.target_y;
      tp_q[2] <= req_i.payload.target_z;
      a_q[0]  <= req_i.payload.seg_start_x;
      a_q[1]  <= req_i.payload.seg_start_y;
      a_q[2]  <= req_i.payload.seg_start_z;
      b_q[0]  <= req_i.payload.seg_end_x;
      b_q[1]  <= req_i.payload.seg_end_y;
      b_q[2]  <= req_i.payload.seg_end_z;
      last_q  <= req_i.payload.last_segment;
    end
    den_q  <= den_d;
    num_q  <= num_d;
    dist_q <= dist_d;
    t_q    <= t_d;
    p_q    <= p_d;
    rsp_q  <= rsp_d;
  end

endmodule

`default_nettype wire
